// File: rtl/core/fcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int PIPE_DEPTH   = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int HALF_SHIFT   = 1;
    localparam int EIGHTH_SHIFT = 3;

    typedef logic signed [DATA_WIDTH-1:0] t_sword;
    typedef logic        [DATA_WIDTH-2:0] t_uword;

    localparam t_sword VMAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_sword VMIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_uword ONE_Q = t_uword'(1) << FRAC_BITS;

    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    localparam logic [1:0] SCHEME_UPWIND  = 2'd0;
    localparam logic [1:0] SCHEME_CENTRAL = 2'd1;
    localparam logic [1:0] SCHEME_QUICK   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCHEME    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_DENS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_DX   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_DY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP = 3'd4;

    // Where the source term of a face comes from.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_FACE,
        SRC_QUICK
    } t_src_kind;

    typedef struct packed {
        logic [1:0]                  face_dir;
        logic                        face_on_boundary;
        logic signed [DATA_WIDTH-1:0] normal_velocity;
        logic [DATA_WIDTH-2:0]       face_density;
        logic signed [DATA_WIDTH-1:0] wall_value;
        logic signed [DATA_WIDTH-1:0] centre_value;
        logic signed [DATA_WIDTH-1:0] near_value;
        logic signed [DATA_WIDTH-1:0] opposite_value;
        logic                        opposite_on_boundary;
        logic signed [DATA_WIDTH-1:0] far_value;
        logic                        far_on_boundary;
    } t_face_in;

    typedef struct packed {
        logic [1:0]                  dir_echo;
        logic signed [DATA_WIDTH-1:0] neighbour_coef;
        logic signed [DATA_WIDTH-1:0] centre_add;
        logic signed [DATA_WIDTH-1:0] source_add;
    } t_face_out;

    function automatic t_sword f_sat_add(input t_sword a, input t_sword b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic t_sword f_sat_sub(input t_sword a, input t_sword b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // Product with a power-of-two fraction: shift the magnitude, truncate toward zero.
    function automatic t_sword f_scale_down(input t_sword a, input int sh);
        logic [DATA_WIDTH-1:0] mag;
        mag = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        mag = mag >> sh;
        return a[DATA_WIDTH-1] ? t_sword'(~mag + 1'b1) : t_sword'(mag);
    endfunction

    function automatic t_sword f_max0(input t_sword a);
        return a[DATA_WIDTH-1] ? t_sword'(0) : a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fcc_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point multiply: exact product, magnitude shifted down, saturated.
module fcc_qmul
    import fcc_pkg::*;
(
    input  t_sword i_a,
    input  t_sword i_b,
    output t_sword o_p
);

    logic                                neg;
    logic [DATA_WIDTH-1:0]               mag_a;
    logic [DATA_WIDTH-1:0]               mag_b;
    logic [2*DATA_WIDTH-1:0]             prod;
    logic [2*DATA_WIDTH-FRAC_BITS-1:0]   shifted;
    logic [DATA_WIDTH-1:0]               low;
    logic                                big;

    always_comb begin
        neg     = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        mag_a   = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
        mag_b   = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
        prod    = mag_a * mag_b;
        shifted = prod[2*DATA_WIDTH-1:FRAC_BITS];
        big     = |shifted[2*DATA_WIDTH-FRAC_BITS-1:DATA_WIDTH-1];
        low     = {1'b0, shifted[DATA_WIDTH-2:0]};
        if (big) begin
            o_p = neg ? VMIN : VMAX;
        end else if (neg) begin
            o_p = t_sword'(~low + 1'b1);
        end else begin
            o_p = t_sword'(low);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/face_convection_coefficients.sv
`timescale 1ns / 1ps
`default_nettype none

// Convection terms of one face of a 2-D finite-volume cell, signed Q16.16. Pulse start
// with a face on i_face; busy stays low, so a new face may enter on every clock. Each
// face returns as one beat on o_result, marked by o_done for exactly one cycle. The
// pipeline stages come from four fixed-point multiplies that sit in series (time step
// by face area, by normal velocity, by density, and the source product) with a register
// after each, plus one stage for the scheme logic and one for the final source scaling.
// There is no backpressure: the receiver must take every beat in the cycle it is shown.
// Write the scheme, density flag, cell sizes and time step over the configuration
// channel (always ready) only while no face is in flight.
module face_convection_coefficients
    import fcc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_face_in                i_face,
    output logic                    o_done,
    output t_face_out               o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [1:0]  r_scheme;
    logic        r_use_dens;
    t_uword      r_cell_dx;
    t_uword      r_cell_dy;
    t_uword      r_time_step;

    // One valid bit per stage; the last one is the output strobe
    logic [PIPE_DEPTH-1:0] r_valid;

    // Stage 1: time step times area
    t_face_in  r_in1;
    t_sword    r_base1;
    t_uword    n_area;
    t_sword    n_base1;

    // Stage 2: flow rate, doubled values for the QUICK stencil
    t_face_in  r_in2;
    t_sword    r_flow2;
    t_sword    r_c2, r_n2, r_r2, r_o2;
    t_sword    n_flow2;

    // Stage 3: density, partial QUICK differences, mirrored neighbours
    t_face_in  r_in3;
    t_sword    r_flow3;
    t_sword    r_ta3, r_tb3, r_far3, r_opp3;
    t_sword    w_dens_flow;
    t_sword    n_flow3;

    // Stage 4: signed flow, coefficients, source operand
    logic [1:0] r_dir4;
    t_src_kind  r_kind4;
    t_sword     r_sflow4, r_nc4, r_ca4, r_opnd4;
    logic       n_lowside;
    t_sword     n_sflow4, n_nc4, n_ca4, n_opnd4, n_d4;
    t_src_kind  n_kind4;

    // Stage 5: source product
    logic [1:0] r_dir5;
    t_src_kind  r_kind5;
    t_sword     r_nc5, r_ca5, r_prod5;
    t_sword     n_prod5;

    // Stage 6: output beat
    t_face_out  r_out6;
    t_sword     n_src6;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_valid[PIPE_DEPTH-1];
    assign o_result    = r_out6;

    // Configuration writes; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme    <= SCHEME_UPWIND;
            r_use_dens  <= 1'b0;
            r_cell_dx   <= ONE_Q;
            r_cell_dy   <= ONE_Q;
            r_time_step <= ONE_Q;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCHEME:    r_scheme    <= i_cfg_data[1:0];
                CFG_USE_DENS:  r_use_dens  <= i_cfg_data[0];
                CFG_CELL_DX:   r_cell_dx   <= i_cfg_data[DATA_WIDTH-2:0];
                CFG_CELL_DY:   r_cell_dy   <= i_cfg_data[DATA_WIDTH-2:0];
                CFG_TIME_STEP: r_time_step <= i_cfg_data[DATA_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    // Advance the valid bits every cycle: the receiver never stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], start && !busy};
        end
    end

    // ---- Stage 1 ----
    // South/north faces use the cell width, west/east faces the cell height
    always_comb begin
        n_area = (i_face.face_dir == DIR_SOUTH || i_face.face_dir == DIR_NORTH)
                 ? r_cell_dx : r_cell_dy;
    end

    fcc_qmul u_mul_base (
        .i_a ({1'b0, r_time_step}),
        .i_b ({1'b0, n_area}),
        .o_p (n_base1)
    );

    // ---- Stage 2 ----
    fcc_qmul u_mul_flow (
        .i_a (r_base1),
        .i_b (r_in1.normal_velocity),
        .o_p (n_flow2)
    );

    // ---- Stage 3 ----
    fcc_qmul u_mul_dens (
        .i_a (r_flow2),
        .i_b ({1'b0, r_in2.face_density}),
        .o_p (w_dens_flow)
    );

    assign n_flow3 = r_use_dens ? w_dens_flow : r_flow2;

    // ---- Stage 4 ----
    // Upwind and QUICK share one neighbour coefficient: the positive part of s*F.
    // QUICK picks the upstream stencil from the flow sign and the face side.
    always_comb begin
        n_lowside = (r_in3.face_dir == DIR_WEST || r_in3.face_dir == DIR_SOUTH);
        n_sflow4  = n_lowside ? r_flow3 : f_sat_sub(t_sword'(0), r_flow3);
        if ((r_flow3 > t_sword'(0)) == n_lowside) begin
            n_d4 = f_sat_sub(r_ta3, r_far3);
        end else begin
            n_d4 = f_sat_sub(r_tb3, r_opp3);
        end

        n_nc4   = '0;
        n_ca4   = '0;
        n_opnd4 = '0;
        n_kind4 = SRC_NONE;
        if (r_in3.face_on_boundary) begin
            n_opnd4 = r_in3.wall_value;
            n_kind4 = SRC_FACE;
        end else begin
            unique case (r_scheme)
                SCHEME_CENTRAL: begin
                    n_nc4 = f_scale_down(n_sflow4, HALF_SHIFT);
                end
                SCHEME_QUICK: begin
                    n_nc4   = f_max0(n_sflow4);
                    n_opnd4 = n_d4;
                    n_kind4 = SRC_QUICK;
                end
                default: begin
                    n_nc4 = f_max0(n_sflow4);
                end
            endcase
            n_ca4 = f_sat_sub(n_nc4, n_sflow4);
        end
    end

    // ---- Stage 5 ----
    fcc_qmul u_mul_src (
        .i_a (r_sflow4),
        .i_b (r_opnd4),
        .o_p (n_prod5)
    );

    // ---- Stage 6 ----
    always_comb begin
        unique case (r_kind5)
            SRC_FACE:  n_src6 = r_prod5;
            SRC_QUICK: n_src6 = f_scale_down(r_prod5, EIGHTH_SHIFT);
            default:   n_src6 = '0;
        endcase
    end

    // Datapath registers: no reset, the valid bits qualify them
    always_ff @(posedge i_clk) begin
        r_in1   <= i_face;
        r_base1 <= n_base1;

        r_in2   <= r_in1;
        r_flow2 <= n_flow2;
        r_c2    <= f_sat_add(r_in1.centre_value, r_in1.centre_value);
        r_n2    <= f_sat_add(r_in1.near_value, r_in1.near_value);
        r_r2    <= f_sat_add(r_in1.far_value, r_in1.far_value);
        r_o2    <= f_sat_add(r_in1.opposite_value, r_in1.opposite_value);

        r_in3   <= r_in2;
        r_flow3 <= n_flow3;
        r_ta3   <= f_sat_sub(f_sat_add(r_c2, r_in2.centre_value), r_n2);
        r_tb3   <= f_sat_sub(f_sat_add(r_n2, r_in2.near_value), r_c2);
        // Mirror boundary values about the inner node
        r_far3  <= r_in2.far_on_boundary ? f_sat_sub(r_r2, r_in2.near_value)
                                         : r_in2.far_value;
        r_opp3  <= r_in2.opposite_on_boundary ? f_sat_sub(r_o2, r_in2.centre_value)
                                              : r_in2.opposite_value;

        r_dir4   <= r_in3.face_dir;
        r_kind4  <= n_kind4;
        r_sflow4 <= n_sflow4;
        r_nc4    <= n_nc4;
        r_ca4    <= n_ca4;
        r_opnd4  <= n_opnd4;

        r_dir5   <= r_dir4;
        r_kind5  <= r_kind4;
        r_nc5    <= r_nc4;
        r_ca5    <= r_ca4;
        r_prod5  <= n_prod5;

        r_out6.dir_echo       <= r_dir5;
        r_out6.neighbour_coef <= r_nc5;
        r_out6.centre_add     <= r_ca5;
        r_out6.source_add     <= n_src6;
    end

endmodule

`default_nettype wire

// File: rtl/core/fcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fcc_checker
    import fcc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  t_face_in                i_face,
    input  logic                    o_done,
    input  t_face_out               o_result
);

    logic w_accept;

    assign w_accept = start && !busy;

    // Every accepted face comes back after the fixed depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_DEPTH o_done)
        else $error("accepted face not delivered after pipeline depth");

    // No beat without a face behind it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##PIPE_DEPTH !o_done)
        else $error("result beat without an accepted face");

    a_dir_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.dir_echo == $past(i_face.face_dir, PIPE_DEPTH)))
        else $error("direction echo does not match its face");

    // Boundary faces only feed the source term
    a_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_face.face_on_boundary, PIPE_DEPTH)) |->
        (o_result.neighbour_coef == '0 && o_result.centre_add == '0))
        else $error("boundary face gave nonzero coefficients");

endmodule

bind face_convection_coefficients fcc_checker u_fcc_checker (.*);

`default_nettype wire
